FILE: rtl/scp_pkg.sv
`timescale 1ns / 1ps

package scp_pkg;

  // Field formats
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int OUT_FRAC_BITS   = 30;
  localparam int ANGLE_W         = 32;
  localparam int OUT_W           = 32;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [OUT_W-1:0]   trig_t;
  typedef logic signed [63:0]        q60_t;

  // Reduction constants, 30 fraction bits
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int SH_IN   = 30 - ANGLE_FRAC_BITS;
  localparam int MAG_W   = ANGLE_W + SH_IN;        // |angle| + pi on the 30-bit grid
  localparam int RED_TSH = 26;                     // drop these bits before the quotient guess
  localparam int RED_RS  = 24;                     // reciprocal fraction bits
  localparam int THI_W   = MAG_W - RED_TSH;
  localparam int K_W     = MAG_W - 32;
  localparam int RECIP_W = 18;
  localparam logic [63:0] RECIP = (64'd1 << (RED_TSH + RED_RS)) / TWO_PI_Q30;
  localparam int R_W     = 35;                     // remainder before correction, < 2 * 2pi
  localparam int R2_W    = 33;                     // remainder after correction, < 2pi
  localparam int XR_W    = 33;                     // reduced angle, signed, |x| <= pi
  localparam int Q_SH    = 30;                     // 30 -> 60 fraction bits

  // Product rounding bias, 60 fraction bits
  localparam logic [127:0] MAC_RND = 128'd1 << 59;
  localparam q60_t ONE_Q60 = 64'd1 << 60;

  // Output rounding and limit
  localparam int SH_OUT = 60 - OUT_FRAC_BITS;
  localparam logic [63:0] RND_OUT = 64'd1 << (SH_OUT - 1);
  localparam int SAT_W = OUT_FRAC_BITS + 1;
  localparam logic [63:0] SAT_LIM64 = 64'd1 << OUT_FRAC_BITS;
  localparam logic [SAT_W-1:0] SAT_LIM = SAT_W'(SAT_LIM64);

  // Coefficient magnitudes: round(mant * 2^60 / 10^e), ties up
  localparam logic [127:0] COS_C0_M =
    ((128'd5 << 61) + 128'd10) / 128'd20;
  localparam logic [127:0] COS_C1_M =
    ((128'd41666638 << 61) + 128'd1000000000) / 128'd2000000000;
  localparam logic [127:0] COS_C2_M =
    ((128'd13888378 << 61) + 128'd10000000000) / 128'd20000000000;
  localparam logic [127:0] COS_C3_M =
    ((128'd24760495 << 61) + 128'd1000000000000) / 128'd2000000000000;
  localparam logic [127:0] COS_C4_M =
    ((128'd26051615 << 61) + 128'd100000000000000) / 128'd200000000000000;
  localparam logic [127:0] SIN_S0_M =
    ((128'd16666667 << 61) + 128'd100000000) / 128'd200000000;
  localparam logic [127:0] SIN_S1_M =
    ((128'd83333310 << 61) + 128'd10000000000) / 128'd20000000000;
  localparam logic [127:0] SIN_S2_M =
    ((128'd19840874 << 61) + 128'd100000000000) / 128'd200000000000;
  localparam logic [127:0] SIN_S3_M =
    ((128'd27525562 << 61) + 128'd10000000000000) / 128'd20000000000000;
  localparam logic [127:0] SIN_S4_M =
    ((128'd23889859 << 61) + 128'd1000000000000000) / 128'd2000000000000000;

  localparam q60_t COS_C0 = 64'(128'd0 - COS_C0_M);
  localparam q60_t COS_C1 = 64'(COS_C1_M);
  localparam q60_t COS_C2 = 64'(128'd0 - COS_C2_M);
  localparam q60_t COS_C3 = 64'(COS_C3_M);
  localparam q60_t COS_C4 = 64'(128'd0 - COS_C4_M);
  localparam q60_t SIN_S0 = 64'(128'd0 - SIN_S0_M);
  localparam q60_t SIN_S1 = 64'(SIN_S1_M);
  localparam q60_t SIN_S2 = 64'(128'd0 - SIN_S2_M);
  localparam q60_t SIN_S3 = 64'(SIN_S3_M);
  localparam q60_t SIN_S4 = 64'(128'd0 - SIN_S4_M);

  // Pipeline map
  localparam int NSTG       = 36;
  localparam int ST_XD_LO   = 6;   // first stage of the reduced-angle delay line
  localparam int ST_XD_HI   = 29;  // reduced angle feeds the last sine product here
  localparam int ST_RD_HI   = 33;  // reflection flag needed at the output rounding
  localparam int ST_CD_LO   = 30;  // cosine waits for the last sine product
  localparam int ST_CD_HI   = 33;

endpackage

FILE: rtl/scp_if.sv
`timescale 1ns / 1ps

interface scp_in_if;
  import scp_pkg::*;
  logic   valid;
  logic   ready;
  angle_t angle;
  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface scp_out_if;
  import scp_pkg::*;
  logic  valid;
  logic  ready;
  trig_t sine_value;
  trig_t cosine_value;
  modport source (output valid, output sine_value, output cosine_value, input ready);
  modport sink   (input valid, input sine_value, input cosine_value, output ready);
endinterface

FILE: rtl/scp_mac.sv
`timescale 1ns / 1ps

// p = c + round(a * b / 2^60), ties away from zero; four register stages
module scp_mac (
  input  logic          clk,
  input  logic          en,
  input  scp_pkg::q60_t a,
  input  scp_pkg::q60_t b,
  input  scp_pkg::q60_t c,
  output scp_pkg::q60_t p,
  output scp_pkg::q60_t b_out
);
  import scp_pkg::*;

  logic [63:0]  am_r, bm_r;
  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [62:0]  res_r;
  q60_t         p_r;
  logic [3:1]   neg_r;
  q60_t         bd_r [1:4];
  logic [127:0] sum;

  // exact 128-bit product plus rounding bias
  always_comb begin
    sum = {64'b0, ll_r} + {32'b0, lh_r, 32'b0} + {32'b0, hl_r, 32'b0}
        + {hh_r, 64'b0} + MAC_RND;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r     <= a[63] ? 64'(-a) : 64'(a);
      bm_r     <= b[63] ? 64'(-b) : 64'(b);
      neg_r[1] <= a[63] ^ b[63];
      bd_r[1]  <= b;

      ll_r     <= {32'b0, am_r[31:0]}  * {32'b0, bm_r[31:0]};
      lh_r     <= {32'b0, am_r[31:0]}  * {32'b0, bm_r[63:32]};
      hl_r     <= {32'b0, am_r[63:32]} * {32'b0, bm_r[31:0]};
      hh_r     <= {32'b0, am_r[63:32]} * {32'b0, bm_r[63:32]};
      neg_r[2] <= neg_r[1];
      bd_r[2]  <= bd_r[1];

      res_r    <= sum[122:60];
      neg_r[3] <= neg_r[2];
      bd_r[3]  <= bd_r[2];

      p_r      <= neg_r[3] ? c - q60_t'({1'b0, res_r}) : c + q60_t'({1'b0, res_r});
      bd_r[4]  <= bd_r[3];
    end
  end

  assign p     = p_r;
  assign b_out = bd_r[4];

endmodule

FILE: rtl/sine_cosine_polynomial_top.sv
// Sine and cosine of a stream of angles.
//
// in_ch carries one angle per item (radians, signed, ANGLE_FRAC_BITS fraction
// bits); out_ch returns one item per angle with its sine and cosine (signed,
// OUT_FRAC_BITS fraction bits, limited to +/-1.0). Items leave in the order
// they came in. Both channels move an item on a clock edge with valid and
// ready high.
//
// Throughput: one item per cycle while the skid register is empty. The
// pipeline has 36 stages: six stages of range reduction, seven chained
// 60-fraction-bit multiply-adds of four stages each (x^2, then the Horner
// steps), and two stages of rounding and limiting, followed by the output
// register.
//
// Reset (rst_n low at a clock edge) empties the pipeline, the output register
// and the skid register. When the receiver stalls, the output register holds
// its item, one more item lands in the skid register, and the whole pipeline
// then freezes; in_ch.ready stays high until the skid register fills.
`timescale 1ns / 1ps

module sine_cosine_polynomial_top (
  input  logic          clk,
  input  logic          rst_n,
  scp_in_if.sink        in_ch,
  scp_out_if.source     out_ch
);
  import scp_pkg::*;

  localparam logic signed [XR_W-1:0] PI_X    = XR_W'(PI_Q30);
  localparam logic signed [XR_W-1:0] NPI_X   = XR_W'(64'd0 - PI_Q30);
  localparam logic signed [XR_W-1:0] HALF_X  = XR_W'(HALF_PI_Q30);
  localparam logic signed [XR_W-1:0] NHALF_X = XR_W'(64'd0 - HALF_PI_Q30);
  localparam logic signed [R_W-1:0]  PI_R    = R_W'(PI_Q30);

  // pipeline control: one enable for all stages, valid bits ride along
  logic            en;
  logic [NSTG-1:0] v_r;

  // range reduction
  logic [ANGLE_W-1:0]       am;
  logic [MAG_W-1:0]         t_nxt, t0_r, t1_r;
  logic [3:0]               sgn_r;
  logic [THI_W+RECIP_W-1:0] kprod;
  logic [K_W-1:0]           k0_r;
  logic [MAG_W-1:0]         kmul;
  logic [R_W-1:0]           r_r;
  logic [R2_W-1:0]          r2_nxt, r2_r;
  logic signed [R_W-1:0]    r2s;
  logic signed [XR_W-1:0]   x_nxt, x_r;
  logic signed [XR_W-1:0]   xr_nxt, xr_r;
  logic                     refl_hi, refl_lo, refl_r;

  // delay lines alongside the multiply chain
  logic signed [XR_W-1:0] xd_r [ST_XD_LO:ST_XD_HI];
  logic                   rd_r [ST_XD_LO:ST_RD_HI];
  q60_t                   cd_r [ST_CD_LO:ST_CD_HI];

  // multiply chain
  q60_t x60_in, x60_late;
  q60_t x2_p;
  q60_t s1_p, s2_p, s3_p, s4_p, s5_p, s6_p;
  q60_t s1_b, s2_b, s3_b, s4_b;
  q60_t c1_p, c2_p, c3_p, c4_p, c5_p;
  q60_t c1_b, c2_b, c3_b, c4_b;

  // output rounding
  logic [63:0]      sm_r, cm_r;
  logic             sn_r, cn_r;
  logic [63:0]      s_rnd, c_rnd;
  logic [SAT_W-1:0] ss_nxt, cs_nxt, ss_r, cs_r;
  logic             sn2_r, cn2_r;
  trig_t            sine_nxt, cosine_nxt;

  // output register and skid register
  logic  out_v_r, skid_v_r;
  trig_t out_sine_r, out_cosine_r, skid_sine_r, skid_cosine_r;
  logic  oreg_free, push;

  // Advance while the skid register is empty; at most one item overflows.
  assign en          = !skid_v_r;
  assign in_ch.ready = en;
  assign push        = en && v_r[NSTG-1];
  assign oreg_free   = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_ch.valid};
    end
  end

  // Stage 0: |angle| on the 30-bit grid, plus pi for round-to-nearest.
  // Stage 1: quotient guess from the top bits times 1/2pi, low by at most one.
  // Stage 2: remainder; Stage 3: fix the guess; Stage 4: back to signed.
  always_comb begin
    am     = in_ch.angle[ANGLE_W-1] ? ANGLE_W'(-in_ch.angle) : ANGLE_W'(in_ch.angle);
    t_nxt  = (MAG_W'(am) << SH_IN) + MAG_W'(PI_Q30);
    kprod  = (THI_W+RECIP_W)'(t0_r[MAG_W-1:RED_TSH]) * RECIP_W'(RECIP);
    kmul   = MAG_W'(k0_r * TWO_PI_Q30);
    r2_nxt = (r_r >= R_W'(TWO_PI_Q30)) ? R2_W'(r_r - R_W'(TWO_PI_Q30)) : R2_W'(r_r);
    r2s    = signed'(R_W'(r2_r));
    x_nxt  = sgn_r[3] ? XR_W'(PI_R - r2s) : XR_W'(r2s - PI_R);
    // Fold into [-pi/2, pi/2]; exactly pi/2 stays.
    refl_hi = x_r > HALF_X;
    refl_lo = x_r < NHALF_X;
    if (refl_hi) begin
      xr_nxt = PI_X - x_r;
    end else if (refl_lo) begin
      xr_nxt = NPI_X - x_r;
    end else begin
      xr_nxt = x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r     <= t_nxt;
      sgn_r[0] <= in_ch.angle[ANGLE_W-1];
      t1_r     <= t0_r;
      k0_r     <= kprod[RED_RS +: K_W];
      sgn_r[1] <= sgn_r[0];
      r_r      <= R_W'(t1_r - kmul);
      sgn_r[2] <= sgn_r[1];
      r2_r     <= r2_nxt;
      sgn_r[3] <= sgn_r[2];
      x_r      <= x_nxt;
      xr_r     <= xr_nxt;
      refl_r   <= refl_hi || refl_lo;
    end
  end

  // Hold the reduced angle and the reflection flag for the later stages.
  always_ff @(posedge clk) begin
    if (en) begin
      xd_r[ST_XD_LO] <= xr_r;
      for (int i = ST_XD_LO + 1; i <= ST_XD_HI; i++) begin
        xd_r[i] <= xd_r[i-1];
      end
      rd_r[ST_XD_LO] <= refl_r;
      for (int i = ST_XD_LO + 1; i <= ST_RD_HI; i++) begin
        rd_r[i] <= rd_r[i-1];
      end
      cd_r[ST_CD_LO] <= c5_p;
      for (int i = ST_CD_LO + 1; i <= ST_CD_HI; i++) begin
        cd_r[i] <= cd_r[i-1];
      end
    end
  end

  assign x60_in   = {{(64-XR_W-Q_SH){xr_r[XR_W-1]}}, xr_r, Q_SH'(0)};
  assign x60_late = {{(64-XR_W-Q_SH){xd_r[ST_XD_HI][XR_W-1]}}, xd_r[ST_XD_HI], Q_SH'(0)};

  // x^2, stages 6..9
  scp_mac u_mac_x2 (.clk(clk), .en(en), .a(x60_in), .b(x60_in), .c('0),
                    .p(x2_p), .b_out());

  // Sine Horner chain, stages 10..29, then x * S in stages 30..33
  scp_mac u_mac_s1 (.clk(clk), .en(en), .a(SIN_S4), .b(x2_p), .c(SIN_S3),
                    .p(s1_p), .b_out(s1_b));
  scp_mac u_mac_s2 (.clk(clk), .en(en), .a(s1_p), .b(s1_b), .c(SIN_S2),
                    .p(s2_p), .b_out(s2_b));
  scp_mac u_mac_s3 (.clk(clk), .en(en), .a(s2_p), .b(s2_b), .c(SIN_S1),
                    .p(s3_p), .b_out(s3_b));
  scp_mac u_mac_s4 (.clk(clk), .en(en), .a(s3_p), .b(s3_b), .c(SIN_S0),
                    .p(s4_p), .b_out(s4_b));
  scp_mac u_mac_s5 (.clk(clk), .en(en), .a(s4_p), .b(s4_b), .c(ONE_Q60),
                    .p(s5_p), .b_out());
  scp_mac u_mac_s6 (.clk(clk), .en(en), .a(s5_p), .b(x60_late), .c('0),
                    .p(s6_p), .b_out());

  // Cosine Horner chain, stages 10..29
  scp_mac u_mac_c1 (.clk(clk), .en(en), .a(COS_C4), .b(x2_p), .c(COS_C3),
                    .p(c1_p), .b_out(c1_b));
  scp_mac u_mac_c2 (.clk(clk), .en(en), .a(c1_p), .b(c1_b), .c(COS_C2),
                    .p(c2_p), .b_out(c2_b));
  scp_mac u_mac_c3 (.clk(clk), .en(en), .a(c2_p), .b(c2_b), .c(COS_C1),
                    .p(c3_p), .b_out(c3_b));
  scp_mac u_mac_c4 (.clk(clk), .en(en), .a(c3_p), .b(c3_b), .c(COS_C0),
                    .p(c4_p), .b_out(c4_b));
  scp_mac u_mac_c5 (.clk(clk), .en(en), .a(c4_p), .b(c4_b), .c(ONE_Q60),
                    .p(c5_p), .b_out());

  // Stage 34: magnitude and sign; a reflected angle flips the cosine sign.
  // Stage 35: round to the output grid and limit to 1.0.
  always_comb begin
    s_rnd      = (sm_r + RND_OUT) >> SH_OUT;
    c_rnd      = (cm_r + RND_OUT) >> SH_OUT;
    ss_nxt     = (s_rnd > SAT_LIM64) ? SAT_LIM : SAT_W'(s_rnd);
    cs_nxt     = (c_rnd > SAT_LIM64) ? SAT_LIM : SAT_W'(c_rnd);
    sine_nxt   = sn2_r ? OUT_W'(0) - OUT_W'(ss_r) : OUT_W'(ss_r);
    cosine_nxt = cn2_r ? OUT_W'(0) - OUT_W'(cs_r) : OUT_W'(cs_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_r  <= s6_p[63] ? 64'(-s6_p) : 64'(s6_p);
      sn_r  <= s6_p[63];
      cm_r  <= cd_r[ST_CD_HI][63] ? 64'(-cd_r[ST_CD_HI]) : 64'(cd_r[ST_CD_HI]);
      cn_r  <= cd_r[ST_CD_HI][63] ^ rd_r[ST_RD_HI];
      ss_r  <= ss_nxt;
      sn2_r <= sn_r;
      cs_r  <= cs_nxt;
      cn2_r <= cn_r;
    end
  end

  // Output register with a one-item skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (oreg_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (oreg_free) begin
      if (skid_v_r) begin
        out_sine_r   <= skid_sine_r;
        out_cosine_r <= skid_cosine_r;
      end else begin
        out_sine_r   <= sine_nxt;
        out_cosine_r <= cosine_nxt;
      end
    end else if (push) begin
      skid_sine_r   <= sine_nxt;
      skid_cosine_r <= cosine_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.sine_value   = out_sine_r;
  assign out_ch.cosine_value = out_cosine_r;

endmodule

FILE: rtl/scp_checker.sv
`timescale 1ns / 1ps

module scp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input scp_pkg::trig_t       sine_value,
  input scp_pkg::trig_t       cosine_value
);
  import scp_pkg::*;

  localparam trig_t POS_ONE = OUT_W'(SAT_LIM64);
  localparam trig_t NEG_ONE = OUT_W'(64'd0 - SAT_LIM64);

  // hold a stalled item
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(sine_value) && $stable(cosine_value))
    else $error("result changed while stalled");

  // limiting keeps both results within +/-1.0
  a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sine_value <= POS_ONE && sine_value >= NEG_ONE)
    else $error("sine beyond one");

  a_cosine_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cosine_value <= POS_ONE && cosine_value >= NEG_ONE)
    else $error("cosine beyond one");

endmodule

bind sine_cosine_polynomial_top scp_checker u_scp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .sine_value   (out_ch.sine_value),
  .cosine_value (out_ch.cosine_value)
);

FILE: dv/tb_sine_cosine_polynomial_top.sv
`timescale 1ns / 1ps

module tb_sine_cosine_polynomial_top;
  import scp_pkg::*;

  // Reduction grid: 30 fraction bits. pi has a single factor of two, so no
  // 24-fraction-bit angle ever lands exactly on an odd multiple of pi.
  localparam longint PI_GRID      = 64'sd3373259426;
  localparam longint HALF_PI_GRID = 64'sd1686629713;
  localparam q60_t   UNIT_Q60     = 64'sd1 <<< 60;

  localparam int RANDOM_ITEMS = 1550;
  localparam int SETTLE_SPIN  = 20000;   // bound on the final drain, in cycles
  localparam int TAIL_CYCLES  = 50;      // pipeline is 36 deep; give it room

  typedef q60_t [4:0] coef_set_t;

  typedef struct packed {
    trig_t sine;
    trig_t cosine;
  } sincos_t;

  // One pending angle; settle asks the driver to wait until the block is empty.
  typedef struct {
    angle_t angle;
    bit     settle;
  } angle_job_t;

  logic clk;
  logic rst_n;

  scp_in_if  in_ch ();
  scp_out_if out_ch ();

  sine_cosine_polynomial_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  angle_job_t angle_backlog[$];
  sincos_t    trig_due[$];
  coef_set_t  cos_coefs;
  coef_set_t  sin_coefs;

  int n_total;
  int n_directed;
  int n_acc;      // angles taken by the block
  int n_got;      // sine/cosine pairs returned
  int n_err;

  // ---------------------------------------------------------------------------
  // Arithmetic of the block, bit for bit
  // ---------------------------------------------------------------------------

  // Decimal coefficient times 2^60, rounded to nearest with ties up.
  function automatic q60_t coef_q60(bit neg, longint unsigned mant, int dexp);
    logic [127:0] den;
    logic [127:0] m;
    int i;
    den = 128'd1;
    for (i = 0; i < dexp; i++) den = den * 128'd10;
    m = ((128'(mant) << 61) + den) / (den << 1);
    return neg ? -q60_t'(m[63:0]) : q60_t'(m[63:0]);
  endfunction

  // Product of two 60-fraction values, rounded to nearest, ties away from zero.
  function automatic q60_t q60_mul(q60_t a, q60_t b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    q60_t         r;
    ua = a[63] ? 64'(-a) : 64'(a);
    ub = b[63] ? 64'(-b) : 64'(b);
    p  = {64'd0, ua} * {64'd0, ub};
    p  = p + (128'd1 << 59);
    r  = q60_t'({1'b0, p[122:60]});
    return (a[63] ^ b[63]) ? -r : r;
  endfunction

  // 1 + x2*(c0 + x2*(c1 + ... x2*c4))
  function automatic q60_t horner_q60(coef_set_t tab, q60_t x2);
    q60_t acc;
    int i;
    acc = q60_mul(q60_t'(tab[4]), x2);
    for (i = 3; i >= 0; i--) acc = q60_mul(acc + q60_t'(tab[i]), x2);
    return acc + UNIT_Q60;
  endfunction

  // Round 60 fraction bits down to the output format and clamp to +/-1.0.
  function automatic trig_t round_to_out(q60_t v);
    localparam int SH = 60 - OUT_FRAC_BITS;
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (SH - 1))) >> SH;
    if (m > (64'd1 << OUT_FRAC_BITS)) m = 64'd1 << OUT_FRAC_BITS;
    r = v[63] ? -m : m;
    return trig_t'(r[31:0]);
  endfunction

  function automatic sincos_t predict_sincos(angle_t a);
    longint  a30;
    longint  mag;
    longint  k;
    longint  rem;
    longint  x30;
    longint  absx;
    bit      refl;
    q60_t    x60;
    q60_t    x2;
    q60_t    s;
    q60_t    c;
    sincos_t res;
    // Widen to the 30-bit grid, pull into [-pi, pi] with ties away from zero.
    a30  = longint'(a) * (64'sd1 <<< (30 - ANGLE_FRAC_BITS));
    mag  = (a30 < 0) ? -a30 : a30;
    k    = (mag + PI_GRID) / (2 * PI_GRID);
    rem  = mag - k * (2 * PI_GRID);
    x30  = (a30 < 0) ? -rem : rem;
    absx = (x30 < 0) ? -x30 : x30;
    // Fold the outer quarters back; exactly pi/2 stays put.
    refl = absx > HALF_PI_GRID;
    if (refl) x30 = ((x30 < 0) ? -PI_GRID : PI_GRID) - x30;
    x60 = q60_t'(x30) <<< 30;
    x2  = q60_mul(x60, x60);
    s   = q60_mul(horner_q60(sin_coefs, x2), x60);
    c   = horner_q60(cos_coefs, x2);
    if (refl) c = -c;
    res.sine   = round_to_out(s);
    res.cosine = round_to_out(c);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer angles from the backlog, predict on acceptance.
  // Idle share per phase: 30%, then 88%, then none.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit took;
    int idle_pct;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.angle <= '0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        trig_due.push_back(predict_sincos(in_ch.angle));
        angle_backlog.pop_front();
        n_acc <= n_acc + 1;
      end
      if (n_acc < n_total / 3)          idle_pct = 30;
      else if (n_acc < 2 * n_total / 3) idle_pct = 88;
      else                              idle_pct = 0;

      if (in_ch.valid && !took) begin
        // hold the offered item until the block takes it
      end else if (angle_backlog.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (angle_backlog[0].settle && (n_got != n_acc + int'(took))) begin
        // drain: hold off until every outstanding pair has come back
        in_ch.valid <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.angle <= angle_backlog[0].angle;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each returned pair with the oldest prediction.
  // Stall share per phase: 88%, then 30%, then none.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sincos_t want;
    int stall_pct;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_got <= n_got + 1;
        if (trig_due.size() == 0) begin
          n_err++;
          $error("unexpected result: sine_value %0d, cosine_value %0d",
                 out_ch.sine_value, out_ch.cosine_value);
        end else begin
          want = trig_due.pop_front();
          if (out_ch.sine_value !== want.sine) begin
            n_err++;
            $error("sine_value: expected %0d (0x%08h), actual %0d (0x%08h)",
                   want.sine, want.sine, out_ch.sine_value, out_ch.sine_value);
          end
          if (out_ch.cosine_value !== want.cosine) begin
            n_err++;
            $error("cosine_value: expected %0d (0x%08h), actual %0d (0x%08h)",
                   want.cosine, want.cosine, out_ch.cosine_value, out_ch.cosine_value);
          end
        end
      end
      if (n_got < n_total / 3)          stall_pct = 88;
      else if (n_got < 2 * n_total / 3) stall_pct = 30;
      else                              stall_pct = 0;
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  task automatic queue_angle(angle_t a, bit settle);
    angle_job_t j;
    j.angle  = a;
    j.settle = settle;
    angle_backlog.push_back(j);
  endtask

  // Angle near a multiple of pi/2, within a few LSBs; reaches the fold points.
  function automatic angle_t near_quarter_turn();
    longint n;
    longint v;
    n = longint'($urandom_range(0, 162)) - 81;
    v = (n * HALF_PI_GRID) / (64'sd1 <<< (30 - ANGLE_FRAC_BITS));
    v = v + longint'($urandom_range(0, 16)) - 8;
    if (v > 64'sd2147483647)  v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return angle_t'(v);
  endfunction

  initial begin
    angle_t dir_angles[$];
    angle_t a;
    int i;
    int spin;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.angle  = '0;
    out_ch.ready = 1'b0;
    n_acc = 0;
    n_got = 0;
    n_err = 0;

    cos_coefs[0] = coef_q60(1'b1, 64'd5,        1);
    cos_coefs[1] = coef_q60(1'b0, 64'd41666638, 9);
    cos_coefs[2] = coef_q60(1'b1, 64'd13888378, 10);
    cos_coefs[3] = coef_q60(1'b0, 64'd24760495, 12);
    cos_coefs[4] = coef_q60(1'b1, 64'd26051615, 14);
    sin_coefs[0] = coef_q60(1'b1, 64'd16666667, 8);
    sin_coefs[1] = coef_q60(1'b0, 64'd83333310, 10);
    sin_coefs[2] = coef_q60(1'b1, 64'd19840874, 11);
    sin_coefs[3] = coef_q60(1'b0, 64'd27525562, 13);
    sin_coefs[4] = coef_q60(1'b1, 64'd23889859, 15);

    // Directed: zero and tiny angles, field extremes, both sides of pi/2
    // (fold or no fold, sine pushing past one), both sides of pi (the
    // rounding of k), 2pi, 3pi, one radian and alternating bit patterns.
    dir_angles = '{32'sd0, 32'sd1, -32'sd1, 32'sd16,
                   32'sh7FFFFFFF, 32'sh80000000,
                   32'sd26353589, 32'sd26353590, -32'sd26353589, -32'sd26353590,
                   32'sd52707178, 32'sd52707179, -32'sd52707178, -32'sd52707179,
                   32'sd105414357, -32'sd105414357,
                   32'sd158121535, 32'sd158121536, -32'sd158121536,
                   32'sd16777216, -32'sd16777216,
                   32'sh55555555, 32'shAAAAAAAA};
    n_directed = dir_angles.size();
    n_total    = n_directed + RANDOM_ITEMS;
    foreach (dir_angles[i]) queue_angle(dir_angles[i], 1'b0);

    // Random: half full range, a quarter within two turns, a quarter hugging
    // the quarter-turn points. Drain the block at the start of random and at
    // each change of idling phase.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 3))
        0, 1: a = angle_t'($urandom());
        2:    a = angle_t'(longint'($urandom_range(0, 421657428)) - 210828714);
        default: a = near_quarter_turn();
      endcase
      queue_angle(a, (i == 0) || (n_directed + i == n_total / 3) ||
                     (n_directed + i == 2 * n_total / 3));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (angle_backlog.size() != 0) @(posedge clk);
    for (spin = 0; trig_due.size() != 0 && spin < SETTLE_SPIN; spin++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (trig_due.size() != 0) begin
      n_err++;
      $error("%0d predicted results never arrived", trig_due.size());
    end

    $display("Covered %0d angles (%0d directed, %0d random) across three idling phases;",
             n_acc, n_directed, n_total - n_directed);
    $display("checked %0d sine/cosine pairs, %0d errors.", n_got, n_err);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
